// File: src/dfr_pkg.sv
`timescale 1ns / 1ps

package dfr_pkg;

   // entries that the register file can describe
   localparam int TableDepth = 16;
   localparam int TableIdxW  = 4;
   localparam int MaxEntries = 16;

   localparam int LengthW    = 5;
   localparam int KindsW     = 32;
   localparam int ValuesW    = 64;
   localparam int CsrIndexW  = 2;
   localparam int CsrDataW   = 64;
   localparam int ByteW      = 8;

   // register indexes on the csr port
   localparam logic [CsrIndexW-1:0] CSR_TABLE_LENGTH = 2'd0;
   localparam logic [CsrIndexW-1:0] CSR_ENTRY_KINDS  = 2'd1;
   localparam logic [CsrIndexW-1:0] CSR_VALUES_LOW   = 2'd2;
   localparam logic [CsrIndexW-1:0] CSR_VALUES_HIGH  = 2'd3;

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_END   = 2'd1,
      KIND_CHECK = 2'd2,
      KIND_DATA  = 2'd3
   } kind_type;

   // format table as held in the csr block
   typedef struct packed {
      logic [LengthW-1:0] table_length;
      logic [KindsW-1:0]  entry_kinds;
      logic [ValuesW-1:0] entry_values_high;
      logic [ValuesW-1:0] entry_values_low;
   } table_cfg_type;

   // one result word
   typedef struct packed {
      logic [ByteW-1:0] out_byte;
      logic             payload_valid;
      logic             check_valid;
      logic             frame_start;
      logic             frame_abort;
      logic             frame_done;
   } rsp_type;

endpackage

// File: src/dfr_csr.sv
`timescale 1ns / 1ps

module dfr_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [dfr_pkg::CsrIndexW-1:0]      csr_index,
   input  logic [dfr_pkg::CsrDataW-1:0]       csr_wdata,
   output dfr_pkg::table_cfg_type             cfg
);

   dfr_pkg::table_cfg_type cfg_ff, cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            dfr_pkg::CSR_TABLE_LENGTH: begin
               cfg_in.table_length = csr_wdata[dfr_pkg::LengthW-1:0];
            end
            dfr_pkg::CSR_ENTRY_KINDS: begin
               cfg_in.entry_kinds = csr_wdata[dfr_pkg::KindsW-1:0];
            end
            dfr_pkg::CSR_VALUES_LOW: begin
               cfg_in.entry_values_low = csr_wdata[dfr_pkg::ValuesW-1:0];
            end
            dfr_pkg::CSR_VALUES_HIGH: begin
               cfg_in.entry_values_high = csr_wdata[dfr_pkg::ValuesW-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: src/dfr_parse.sv
`timescale 1ns / 1ps

module dfr_parse #(
   parameter int MAX_ENTRIES = dfr_pkg::MaxEntries
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dfr_pkg::table_cfg_type        cfg,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [dfr_pkg::ByteW-1:0]     req_rx_byte,
   output logic                          res_valid,
   input  logic                          res_ready,
   output dfr_pkg::rsp_type              res
);

   localparam int IdxW  = (MAX_ENTRIES > 2) ? $clog2(MAX_ENTRIES) : 1;
   localparam int LenW  = $clog2(MAX_ENTRIES + 1);
   localparam int CalcW = (LenW > dfr_pkg::LengthW) ? LenW : dfr_pkg::LengthW;

   // input word register
   logic                      hold_valid_ff, hold_valid_in;
   logic [dfr_pkg::ByteW-1:0] rx_ff, rx_in;

   // frame state
   logic            in_frame_ff, in_frame_in;
   logic [IdxW-1:0] entry_index_ff, entry_index_in;

   logic                           advance;
   logic [CalcW-1:0]               len_raw, len, last, next;
   logic                           beyond;
   logic [dfr_pkg::TableIdxW-1:0]  lookup;
   logic [2*dfr_pkg::ValuesW-1:0]  values;
   dfr_pkg::kind_type              kind;
   logic [dfr_pkg::ByteW-1:0]      value;
   dfr_pkg::rsp_type               res_w;

   assign advance       = hold_valid_ff && res_ready;
   assign req_ready     = !hold_valid_ff || res_ready;
   assign hold_valid_in = (req_valid && req_ready) || (hold_valid_ff && !res_ready);
   assign rx_in         = (req_valid && req_ready) ? req_rx_byte : rx_ff;

   // length clamp and next entry position
   assign len_raw = CalcW'(cfg.table_length);
   assign len     = (len_raw > CalcW'(MAX_ENTRIES)) ? CalcW'(MAX_ENTRIES) : len_raw;
   assign last    = len - CalcW'(1);
   assign next    = CalcW'(entry_index_ff) + CalcW'(1);

   // table lookup; entries past storage read as start mark with zero value
   assign values = {cfg.entry_values_high, cfg.entry_values_low};
   assign beyond = next >= CalcW'(dfr_pkg::TableDepth);
   assign lookup = next[dfr_pkg::TableIdxW-1:0];
   assign kind   = beyond ? dfr_pkg::KIND_START
                          : dfr_pkg::kind_type'(cfg.entry_kinds[2*lookup +: 2]);
   assign value  = beyond ? '0 : values[dfr_pkg::ByteW*lookup +: dfr_pkg::ByteW];

   // decision for the held word
   always_comb begin
      res_w          = '0;
      res_w.out_byte = rx_ff;
      in_frame_in    = in_frame_ff;
      entry_index_in = entry_index_ff;
      if (len != '0) begin
         if (!in_frame_ff) begin
            if (rx_ff == cfg.entry_values_low[dfr_pkg::ByteW-1:0]) begin
               in_frame_in       = 1'b1;
               entry_index_in    = '0;
               res_w.frame_start = 1'b1;
            end else begin
               res_w.frame_abort = 1'b1;
            end
         end else if (next >= last) begin
            res_w.frame_done = 1'b1;
            in_frame_in      = 1'b0;
            entry_index_in   = '0;
         end else begin
            entry_index_in = next[IdxW-1:0];
            case (kind)
               dfr_pkg::KIND_START, dfr_pkg::KIND_END: begin
                  if (rx_ff != value) begin
                     res_w.frame_abort = 1'b1;
                     in_frame_in       = 1'b0;
                     entry_index_in    = '0;
                  end
               end
               dfr_pkg::KIND_CHECK: begin
                  res_w.check_valid = 1'b1;
               end
               default: begin
                  res_w.payload_valid = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rx_ff <= rx_in;
      if (reset) begin
         hold_valid_ff  <= 1'b0;
         in_frame_ff    <= 1'b0;
         entry_index_ff <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         if (advance) begin
            in_frame_ff    <= in_frame_in;
            entry_index_ff <= entry_index_in;
         end
      end
   end

   assign res_valid = hold_valid_ff;
   assign res       = res_w;

endmodule

// File: src/dfr_out.sv
`timescale 1ns / 1ps

module dfr_out (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       res_valid,
   output logic                       res_ready,
   input  dfr_pkg::rsp_type           res,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output dfr_pkg::rsp_type           rsp
);

   logic             valid_ff, valid_in;
   dfr_pkg::rsp_type rsp_ff, rsp_in;

   // result register, loads whenever empty or being drained
   assign res_ready = !valid_ff || rsp_ready;
   assign valid_in  = res_ready ? res_valid : valid_ff;
   assign rsp_in    = (res_ready && res_valid) ? res : rsp_ff;

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

// File: src/table_driven_frame_deframer.sv
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// req       in         req_valid/req_ready    req_rx_byte
// rsp       out        rsp_valid/rsp_ready    rsp_out_byte and five flags
// csr       in         csr_write_enable       csr_index, csr_wdata
//
// one word per cycle unless rsp stalls; input register, then result register
// the frame state advances as a word moves from the input register to the result register
// synchronous active-high reset empties both registers and returns to hunting
// rsp stall holds the result register; req_ready drops only when both registers are full

module table_driven_frame_deframer #(
   parameter int MAX_ENTRIES = dfr_pkg::MaxEntries
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [dfr_pkg::ByteW-1:0]         req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [dfr_pkg::ByteW-1:0]         rsp_out_byte,
   output logic                              rsp_payload_valid,
   output logic                              rsp_check_valid,
   output logic                              rsp_frame_start,
   output logic                              rsp_frame_abort,
   output logic                              rsp_frame_done,
   input  logic                              csr_write_enable,
   input  logic [dfr_pkg::CsrIndexW-1:0]     csr_index,
   input  logic [dfr_pkg::CsrDataW-1:0]      csr_wdata
);

   dfr_pkg::table_cfg_type cfg;
   dfr_pkg::rsp_type       res;
   dfr_pkg::rsp_type       rsp;
   logic                   res_valid;
   logic                   res_ready;

   dfr_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg              (cfg)
   );

   dfr_parse #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_parse (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res)
   );

   dfr_out u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_out_byte      = rsp.out_byte;
   assign rsp_payload_valid = rsp.payload_valid;
   assign rsp_check_valid   = rsp.check_valid;
   assign rsp_frame_start   = rsp.frame_start;
   assign rsp_frame_abort   = rsp.frame_abort;
   assign rsp_frame_done    = rsp.frame_done;

   // at most one flag per result word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_payload_valid, rsp_check_valid, rsp_frame_start,
                              rsp_frame_abort, rsp_frame_done}))
      else $error("more than one flag set on a result word");

   // a start result carries the head entry's byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_start) |-> (rsp_out_byte == cfg.entry_values_low[7:0]))
      else $error("frame start on a byte that differs from the head entry");

   // an empty table raises no frame flags
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_frame_start || rsp_frame_abort || rsp_frame_done ||
                     rsp_payload_valid || rsp_check_valid))
      |-> (cfg.table_length != '0))
      else $error("frame flag raised with an empty table");

endmodule
